/* src/mpr_pkg.sv */
// ============================================================================
// mpr_pkg
// Shared constants for the memory polynomial regressor: register codes,
// register widths and reset values, and the default sizing of the block.
// ============================================================================
package mpr_pkg;

   // Default sizing, handed to the top level as parameter defaults.
   localparam int MAX_HALF_WINDOW_DEF = 8;
   localparam int MAX_DEGREE_DEF      = 4;
   localparam int SAMPLE_WIDTH_DEF    = 16;

   // Register port.
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CSR_INDEX_W-1:0] REG_HALF_WINDOW = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_DEGREE      = 2'd1;

   // Register widths and reset values.
   localparam int HALF_WINDOW_W = 4;
   localparam int DEGREE_W      = 3;

   localparam logic [HALF_WINDOW_W-1:0] HALF_WINDOW_RST = 4'd1;
   localparam logic [DEGREE_W-1:0]      DEGREE_RST      = 3'd1;

   // Width used when clamping the window size; holds twice the largest
   // supported half window.
   localparam int CLAMP_W = 6;
   // Width used when clamping the degree.
   localparam int DEG_CLAMP_W = 4;

endpackage

/* src/mpr_front.sv */
// ============================================================================
// mpr_front
// Holds the configuration registers and the fill count, takes sample words
// and turns each into a job for the back end: the sample, whether it
// completes a row, and the clamped row geometry.
// ============================================================================
module mpr_front #(
   parameter int MAX_HALF_WINDOW = mpr_pkg::MAX_HALF_WINDOW_DEF,
   parameter int MAX_DEGREE      = mpr_pkg::MAX_DEGREE_DEF,
   parameter int SAMPLE_WIDTH    = mpr_pkg::SAMPLE_WIDTH_DEF,
   localparam int WIN_DEPTH      = 2 * MAX_HALF_WINDOW,
   localparam int TAP_W          = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1,
   localparam int POW_W          = $clog2(MAX_DEGREE + 1),
   localparam int FILL_W         = $clog2(WIN_DEPTH + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mpr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mpr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_sample,
   input  logic                             req_new_vector,
   input  logic                             job_full,
   output logic                             job_push,
   output logic [SAMPLE_WIDTH+1+2*TAP_W+POW_W-1:0] job_data
);

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] sample;
      logic                    emit;
      logic [TAP_W-1:0]        base;
      logic [TAP_W-1:0]        last_tap;
      logic [POW_W-1:0]        deg;
   } job_type;

   logic [mpr_pkg::HALF_WINDOW_W-1:0] half_window_ff;
   logic [mpr_pkg::DEGREE_W-1:0]      degree_ff;
   logic [FILL_W-1:0]                 fill_count_ff;
   logic [FILL_W-1:0]                 fill_count_in;
   logic [FILL_W-1:0]                 fill_base;
   logic [mpr_pkg::CLAMP_W-1:0]       k_c;
   logic [mpr_pkg::CLAMP_W-1:0]       span_c;
   logic [mpr_pkg::DEG_CLAMP_W-1:0]   d_c;
   job_type                           job;

   assign csr_ready = 1'b1;
   assign req_ready = !job_full;
   assign job_push  = req_valid && req_ready;
   assign job_data  = job;

   always_comb begin
      k_c = mpr_pkg::CLAMP_W'(half_window_ff);
      if (k_c == '0) begin
         k_c = mpr_pkg::CLAMP_W'(1);
      end else if (k_c > mpr_pkg::CLAMP_W'(MAX_HALF_WINDOW)) begin
         k_c = mpr_pkg::CLAMP_W'(MAX_HALF_WINDOW);
      end
      span_c = k_c << 1;

      d_c = mpr_pkg::DEG_CLAMP_W'(degree_ff);
      if (d_c == '0) begin
         d_c = mpr_pkg::DEG_CLAMP_W'(1);
      end else if (d_c > mpr_pkg::DEG_CLAMP_W'(MAX_DEGREE)) begin
         d_c = mpr_pkg::DEG_CLAMP_W'(MAX_DEGREE);
      end

      // A new-vector mark restarts the count; the marked sample counts as one.
      fill_base = req_new_vector ? '0 : fill_count_ff;
      if (fill_base == FILL_W'(WIN_DEPTH)) begin
         fill_count_in = fill_base;
      end else begin
         fill_count_in = fill_base + FILL_W'(1);
      end

      job.sample   = req_sample;
      job.emit     = mpr_pkg::CLAMP_W'(fill_count_in) >= span_c;
      job.base     = TAP_W'(mpr_pkg::CLAMP_W'(WIN_DEPTH) - span_c);
      job.last_tap = TAP_W'(span_c - mpr_pkg::CLAMP_W'(1));
      job.deg      = POW_W'(d_c);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_window_ff <= mpr_pkg::HALF_WINDOW_RST;
         degree_ff      <= mpr_pkg::DEGREE_RST;
         fill_count_ff  <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               mpr_pkg::REG_HALF_WINDOW: begin
                  half_window_ff <= csr_wdata[mpr_pkg::HALF_WINDOW_W-1:0];
               end
               mpr_pkg::REG_DEGREE: begin
                  degree_ff <= csr_wdata[mpr_pkg::DEGREE_W-1:0];
               end
               default: begin
               end
            endcase
         end
         if (job_push) begin
            fill_count_ff <= fill_count_in;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      fill_count_ff <= FILL_W'(WIN_DEPTH))
      else $error("fill count beyond window depth");

   assert property (@(posedge clock) disable iff (reset)
      job_push && req_new_vector |=> fill_count_ff == FILL_W'(1))
      else $error("new-vector mark did not restart the fill count");

   assert property (@(posedge clock) disable iff (reset)
      job_full |-> !job_push)
      else $error("job pushed into a full queue");

endmodule

/* src/mpr_queue.sv */
// ============================================================================
// mpr_queue
// Two-entry job queue between the front end and the back end.
// ============================================================================
module mpr_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);

   localparam int DEPTH = 2;

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic             wr_ptr_ff;
   logic             rd_ptr_ff;
   logic [1:0]       count_ff;

   assign full      = count_ff == 2'(DEPTH);
   assign not_empty = count_ff != '0;
   assign pop_data  = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'(DEPTH))
      else $error("queue count overflow");

   assert property (@(posedge clock) disable iff (reset)
      !not_empty |-> !pop)
      else $error("pop from an empty queue");

   assert property (@(posedge clock) disable iff (reset)
      push && !pop |=> count_ff == $past(count_ff) + 2'd1)
      else $error("queue count did not follow a push");

endmodule

/* src/mpr_back.sv */
// ============================================================================
// mpr_back
// Owns the sample window and walks one row per emitting job: taps oldest
// first, powers one to degree, one multiply per power above the first.
// ============================================================================
module mpr_back #(
   parameter int MAX_HALF_WINDOW = mpr_pkg::MAX_HALF_WINDOW_DEF,
   parameter int MAX_DEGREE      = mpr_pkg::MAX_DEGREE_DEF,
   parameter int SAMPLE_WIDTH    = mpr_pkg::SAMPLE_WIDTH_DEF,
   localparam int WIN_DEPTH      = 2 * MAX_HALF_WINDOW,
   localparam int TAP_W          = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1,
   localparam int POW_W          = $clog2(MAX_DEGREE + 1),
   localparam int PROD_W         = 2 * SAMPLE_WIDTH
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           job_valid,
   output logic                           job_pop,
   input  logic [SAMPLE_WIDTH+1+2*TAP_W+POW_W-1:0] job_data,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0] rsp_value,
   output logic [TAP_W-1:0]               rsp_tap,
   output logic [POW_W-1:0]               rsp_power,
   output logic                           rsp_row_end
);

   typedef struct packed {
      logic [SAMPLE_WIDTH-1:0] sample;
      logic                    emit;
      logic [TAP_W-1:0]        base;
      logic [TAP_W-1:0]        last_tap;
      logic [POW_W-1:0]        deg;
   } job_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOAD,
      ST_RUN
   } state_type;

   job_type                        job;
   state_type                      state_ff;
   logic [SAMPLE_WIDTH-1:0]        window_ff [WIN_DEPTH];
   logic [TAP_W-1:0]               base_ff;
   logic [TAP_W-1:0]               last_tap_ff;
   logic [POW_W-1:0]               deg_ff;
   logic [TAP_W-1:0]               tap_ff;
   logic [POW_W-1:0]               pow_ff;
   logic signed [SAMPLE_WIDTH-1:0] x_ff;
   logic signed [SAMPLE_WIDTH-1:0] pw_ff;
   logic                           rsp_valid_ff;
   logic signed [SAMPLE_WIDTH-1:0] rsp_value_ff;
   logic [TAP_W-1:0]               rsp_tap_ff;
   logic [POW_W-1:0]               rsp_power_ff;
   logic                           rsp_row_end_ff;

   logic [TAP_W-1:0]               tap_inc;
   logic [TAP_W-1:0]               rd_idx;
   logic signed [SAMPLE_WIDTH-1:0] rd_x;
   logic signed [PROD_W-1:0]       prod;
   logic signed [PROD_W-1:0]       prod_sh;
   logic signed [SAMPLE_WIDTH-1:0] pw_sat;
   logic                           out_free;
   logic                           emit_word;
   logic                           last_word;

   assign job       = job_data;
   assign job_pop   = (state_ff == ST_IDLE) && job_valid;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_word = (state_ff == ST_RUN) && out_free;
   assign last_word = (tap_ff == last_tap_ff) && (pow_ff == deg_ff);

   // Window read: the oldest tap on a row start, the next tap while running.
   assign tap_inc = tap_ff + TAP_W'(1);
   assign rd_idx  = base_ff + ((state_ff == ST_RUN) ? tap_inc : TAP_W'(0));
   assign rd_x    = window_ff[rd_idx];

   // Next power: Q1.15 product, floor shift, saturate.
   assign prod    = pw_ff * x_ff;
   assign prod_sh = prod >>> (SAMPLE_WIDTH - 1);
   always_comb begin
      if ((&prod_sh[PROD_W-1:SAMPLE_WIDTH-1]) || !(|prod_sh[PROD_W-1:SAMPLE_WIDTH-1])) begin
         pw_sat = prod_sh[SAMPLE_WIDTH-1:0];
      end else if (prod_sh[PROD_W-1]) begin
         pw_sat = {1'b1, {(SAMPLE_WIDTH-1){1'b0}}};
      end else begin
         pw_sat = {1'b0, {(SAMPLE_WIDTH-1){1'b1}}};
      end
   end

   // Window shift line, newest at the top.
   always_ff @(posedge clock) begin
      if (job_pop) begin
         for (int i = 0; i < WIN_DEPTH - 1; i++) begin
            window_ff[i] <= window_ff[i+1];
         end
         window_ff[WIN_DEPTH-1] <= job.sample;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // The output register empties only when no new word replaces it.
         if (rsp_valid_ff && rsp_ready && !emit_word) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (job_pop) begin
                  base_ff     <= job.base;
                  last_tap_ff <= job.last_tap;
                  deg_ff      <= job.deg;
                  if (job.emit) begin
                     state_ff <= ST_LOAD;
                  end
               end
            end
            ST_LOAD: begin
               x_ff     <= rd_x;
               pw_ff    <= rd_x;
               tap_ff   <= '0;
               pow_ff   <= POW_W'(1);
               state_ff <= ST_RUN;
            end
            ST_RUN: begin
               if (out_free) begin
                  rsp_valid_ff   <= 1'b1;
                  rsp_value_ff   <= pw_ff;
                  rsp_tap_ff     <= tap_ff;
                  rsp_power_ff   <= pow_ff;
                  rsp_row_end_ff <= last_word;
                  if (last_word) begin
                     state_ff <= ST_IDLE;
                  end else if (pow_ff == deg_ff) begin
                     tap_ff <= tap_inc;
                     pow_ff <= POW_W'(1);
                     x_ff   <= rd_x;
                     pw_ff  <= rd_x;
                  end else begin
                     pow_ff <= pow_ff + POW_W'(1);
                     pw_ff  <= pw_sat;
                  end
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_value   = rsp_value_ff;
   assign rsp_tap     = rsp_tap_ff;
   assign rsp_power   = rsp_power_ff;
   assign rsp_row_end = rsp_row_end_ff;

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> pow_ff != '0 && pow_ff <= deg_ff)
      else $error("power counter outside one to degree");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_RUN |-> tap_ff <= last_tap_ff)
      else $error("tap counter ran past the row");

   assert property (@(posedge clock) disable iff (reset)
      emit_word && last_word |=> state_ff == ST_IDLE && rsp_valid_ff && rsp_row_end_ff)
      else $error("row end word not followed by return to idle");

   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_LOAD |=> state_ff == ST_RUN && tap_ff == '0 && pow_ff == POW_W'(1))
      else $error("row did not start at the oldest tap, first power");

endmodule

/* src/memory_polynomial_regressor.sv */
// ============================================================================
// memory_polynomial_regressor
// Q1.15 memory polynomial regressor: a sliding window of 2k samples emits,
// per sample, one row of powers x^1..x^degree for every tap, oldest first.
// ============================================================================
// Usage. Sample words enter on the req_ channel (req_sample, req_new_vector)
// and result words leave on the rsp_ channel, one word per power per tap,
// with rsp_row_end high on the last word of a row. Both channels use a
// valid/ready handshake. The csr_ channel writes half_window (index 0) and
// degree (index 1); it is always ready, writes to other indexes are dropped,
// and a write is meant to happen only while no row is in progress.
// A new-vector mark restarts the fill count; a sample that leaves fewer than
// 2k samples since the last mark produces no words.
// Timing. The front end takes a sample per cycle while its two-entry job
// queue has room. The back end takes each job and shifts the window in
// its idle state; for a sample that yields a row it then fetches the
// oldest tap in its load state and gives one word per cycle from the
// single multiplier loop while the output register is free.
// Reset (synchronous, active high) empties the queue and the fill count,
// drops rsp_valid and sets half_window and degree to one. When the receiver
// stalls, the word waits in the output register, the row walk pauses, and
// the queue fills before req_ready falls.
// ============================================================================
module memory_polynomial_regressor #(
   parameter int MAX_HALF_WINDOW = mpr_pkg::MAX_HALF_WINDOW_DEF,
   parameter int MAX_DEGREE      = mpr_pkg::MAX_DEGREE_DEF,
   parameter int SAMPLE_WIDTH    = mpr_pkg::SAMPLE_WIDTH_DEF,
   localparam int WIN_DEPTH      = 2 * MAX_HALF_WINDOW,
   localparam int TAP_W          = (WIN_DEPTH > 1) ? $clog2(WIN_DEPTH) : 1,
   localparam int POW_W          = $clog2(MAX_DEGREE + 1)
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_valid,
   output logic                             csr_ready,
   input  logic [mpr_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  logic [mpr_pkg::CSR_DATA_W-1:0]   csr_wdata,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic signed [SAMPLE_WIDTH-1:0]   req_sample,
   input  logic                             req_new_vector,
   output logic                             rsp_valid,
   input  logic                             rsp_ready,
   output logic signed [SAMPLE_WIDTH-1:0]   rsp_value,
   output logic [TAP_W-1:0]                 rsp_tap,
   output logic [POW_W-1:0]                 rsp_power,
   output logic                             rsp_row_end
);

   // Job word: sample, row flag, window base, last tap, degree.
   localparam int JOB_W = SAMPLE_WIDTH + 1 + 2 * TAP_W + POW_W;

   logic             job_push;
   logic             job_pop;
   logic             job_full;
   logic             job_not_empty;
   logic [JOB_W-1:0] job_wr;
   logic [JOB_W-1:0] job_rd;

   // Front end: registers, fill count and per-sample classification.
   mpr_front #(
      .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
      .MAX_DEGREE      (MAX_DEGREE),
      .SAMPLE_WIDTH    (SAMPLE_WIDTH)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_new_vector (req_new_vector),
      .job_full       (job_full),
      .job_push       (job_push),
      .job_data       (job_wr)
   );

   // Short queue so the front end keeps taking samples during a row.
   mpr_queue #(
      .WIDTH (JOB_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (job_push),
      .push_data (job_wr),
      .full      (job_full),
      .pop       (job_pop),
      .not_empty (job_not_empty),
      .pop_data  (job_rd)
   );

   // Back end: window, power loop and output register.
   mpr_back #(
      .MAX_HALF_WINDOW (MAX_HALF_WINDOW),
      .MAX_DEGREE      (MAX_DEGREE),
      .SAMPLE_WIDTH    (SAMPLE_WIDTH)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .job_valid   (job_not_empty),
      .job_pop     (job_pop),
      .job_data    (job_rd),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_value   (rsp_value),
      .rsp_tap     (rsp_tap),
      .rsp_power   (rsp_power),
      .rsp_row_end (rsp_row_end)
   );

endmodule

/* bench/memory_polynomial_regressor_tb.sv */
`timescale 1ns / 1ps
// ============================================================================
// memory_polynomial_regressor_tb
// Self-checking bench for the Q1.15 memory polynomial regressor. A scoreboard
// keeps its own copy of the sample window, fill count and registers and
// builds every expected result word. Stimulus runs a directed pass over the
// extremes, clamped register values and new-vector marks, then random phases
// under several register settings with random idling on both channels.
// ============================================================================
module memory_polynomial_regressor_tb;

   localparam int SW      = mpr_pkg::SAMPLE_WIDTH_DEF;
   localparam int DEPTH   = 2 * mpr_pkg::MAX_HALF_WINDOW_DEF;
   localparam int TAP_W   = $clog2(DEPTH);
   localparam int POW_W   = $clog2(mpr_pkg::MAX_DEGREE_DEF + 1);
   localparam int REPORTS = 10;

   typedef logic signed [SW-1:0] q15_type;

   // One result word as the block should present it.
   typedef struct packed {
      q15_type          value;
      logic [TAP_W-1:0] tap;
      logic [POW_W-1:0] power;
      logic             row_end;
   } row_word_type;

   // -------------------------------------------------------------------------
   // Scoreboard: mirrors the window and registers and queues the row words
   // that each accepted sample produces.
   // -------------------------------------------------------------------------
   class regressor_scoreboard;
      q15_type                           window [DEPTH];
      int                                fill_count;
      logic [mpr_pkg::HALF_WINDOW_W-1:0] half_window;
      logic [mpr_pkg::DEGREE_W-1:0]      degree;
      row_word_type                      expected_words [$];
      int                                failures;

      function new();
         foreach (window[i]) window[i] = '0;
         fill_count  = 0;
         half_window = mpr_pkg::HALF_WINDOW_RST;
         degree      = mpr_pkg::DEGREE_RST;
         failures    = 0;
      endfunction

      function void set_register(logic [mpr_pkg::CSR_INDEX_W-1:0] index,
                                 logic [mpr_pkg::CSR_DATA_W-1:0] data);
         case (index)
            mpr_pkg::REG_HALF_WINDOW: half_window = data[mpr_pkg::HALF_WINDOW_W-1:0];
            mpr_pkg::REG_DEGREE:      degree      = data[mpr_pkg::DEGREE_W-1:0];
            default: ;
         endcase
      endfunction

      // Q1.15 product: floor shift by 15, then saturate.
      function q15_type q15_product(q15_type a, q15_type b);
         int prod;
         prod = (int'(a) * int'(b)) >>> (SW - 1);
         if (prod > 32767) return 16'sh7FFF;
         if (prod < -32768) return 16'sh8000;
         return q15_type'(prod);
      endfunction

      function void note_sample(q15_type sample, logic mark);
         int           span;
         int           top_power;
         q15_type      x;
         q15_type      pw;
         row_word_type w;
         // Out-of-range register values are pulled into the supported range.
         span = (half_window == 0) ? 1 :
                (half_window > mpr_pkg::MAX_HALF_WINDOW_DEF) ?
                   mpr_pkg::MAX_HALF_WINDOW_DEF : half_window;
         span = 2 * span;
         top_power = (degree == 0) ? 1 :
                     (degree > mpr_pkg::MAX_DEGREE_DEF) ? mpr_pkg::MAX_DEGREE_DEF : degree;
         if (mark) begin
            foreach (window[i]) window[i] = '0;
            fill_count = 0;
         end
         for (int i = 0; i < DEPTH - 1; i++) window[i] = window[i+1];
         window[DEPTH-1] = sample;
         if (fill_count < DEPTH) fill_count++;
         if (fill_count < span) return;
         for (int j = 0; j < span; j++) begin
            x  = window[DEPTH - span + j];
            pw = x;
            for (int p = 1; p <= top_power; p++) begin
               if (p > 1) pw = q15_product(pw, x);
               w.value   = pw;
               w.tap     = TAP_W'(j);
               w.power   = POW_W'(p);
               w.row_end = (j == span - 1) && (p == top_power);
               expected_words.push_back(w);
            end
         end
      endfunction

      function void check_word(row_word_type got);
         row_word_type want;
         if (expected_words.size() == 0) begin
            failures++;
            if (failures <= REPORTS)
               $display("%0t: unexpected word value=%0d tap=%0d power=%0d row_end=%0b",
                        $realtime, got.value, got.tap, got.power, got.row_end);
            return;
         end
         want = expected_words.pop_front();
         if (got !== want) begin
            failures++;
            if (failures <= REPORTS)
               $display({"%0t: word mismatch, expected value=%0d tap=%0d power=%0d ",
                         "row_end=%0b, got value=%0d tap=%0d power=%0d row_end=%0b"},
                        $realtime, want.value, want.tap, want.power, want.row_end,
                        got.value, got.tap, got.power, got.row_end);
         end
      endfunction

      function int words_pending();
         return expected_words.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Clock, reset and the block itself.
   // -------------------------------------------------------------------------
   logic                            clock = 1'b0;
   logic                            reset = 1'b1;
   logic                            csr_valid = 1'b0;
   logic                            csr_ready;
   logic [mpr_pkg::CSR_INDEX_W-1:0] csr_index = '0;
   logic [mpr_pkg::CSR_DATA_W-1:0]  csr_wdata = '0;
   logic                            req_valid = 1'b0;
   logic                            req_ready;
   q15_type                         req_sample = '0;
   logic                            req_new_vector = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_ready = 1'b0;
   q15_type                         rsp_value;
   logic [TAP_W-1:0]                rsp_tap;
   logic [POW_W-1:0]                rsp_power;
   logic                            rsp_row_end;

   // Shared control between the stimulus and the receiver. When quiet is
   // set neither side idles; hold_request asks the receiver for one long
   // stall so that the block backs up into its input.
   bit quiet        = 1'b0;
   bit hold_request = 1'b0;

   regressor_scoreboard sb = new();

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   memory_polynomial_regressor uut (
      .clock          (clock),
      .reset          (reset),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_sample     (req_sample),
      .req_new_vector (req_new_vector),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_value      (rsp_value),
      .rsp_tap        (rsp_tap),
      .rsp_power      (rsp_power),
      .rsp_row_end    (rsp_row_end)
   );

   // -------------------------------------------------------------------------
   // Monitors. Everything is sampled at the rising edge, while the bench only
   // changes inputs at the falling edge, so there is no ordering hazard.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_valid && csr_ready) sb.set_register(csr_index, csr_wdata);
         if (req_valid && req_ready) sb.note_sample(req_sample, req_new_vector);
         if (rsp_valid && rsp_ready)
            sb.check_word('{value: rsp_value, tap: rsp_tap, power: rsp_power,
                            row_end: rsp_row_end});
      end
   end

   // -------------------------------------------------------------------------
   // Receiver. Ready is decided once per falling edge and then held for a
   // while: short random stalls, longer ready stretches, and on request one
   // long stall counted here in its own loop.
   // -------------------------------------------------------------------------
   initial begin
      int hold_left;
      @(negedge clock);
      forever begin
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            for (hold_left = 400; hold_left > 0; hold_left--) @(negedge clock);
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(negedge clock);
         end
      end
   end

   // -------------------------------------------------------------------------
   // Stimulus tasks. Each one starts and ends at a falling edge.
   // -------------------------------------------------------------------------

   // Offers one sample word, sometimes after a random idle burst, and returns
   // once it has been taken. Valid stays high into the next offer when no
   // gap is drawn.
   task automatic offer_sample(input q15_type sample, input logic mark);
      if (!quiet && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 13)) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_sample     <= sample;
      req_new_vector <= mark;
      do @(posedge clock); while (!req_ready);
      @(negedge clock);
   endtask

   // Stops sending and waits for every expected word, then a little longer
   // in case the block is still working through a sample that gives no row.
   task automatic drain_words();
      req_valid <= 1'b0;
      while (sb.words_pending() != 0) @(negedge clock);
      repeat (12) @(negedge clock);
   endtask

   // One register write; only called while the block is idle.
   task automatic write_register(input logic [mpr_pkg::CSR_INDEX_W-1:0] index,
                                 input logic [mpr_pkg::CSR_DATA_W-1:0] data);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
      @(negedge clock);
   endtask

   // Samples lean toward the corners of the Q1.15 range.
   function automatic q15_type pick_sample();
      case ($urandom_range(0, 9))
         0:       return 16'sh8000;
         1:       return 16'sh7FFF;
         2:       return 16'shFFFF;
         3:       return 16'sh0000;
         4:       return 16'sh0001;
         default: return q15_type'($urandom);
      endcase
   endfunction

   // -------------------------------------------------------------------------
   // Main sequence.
   // -------------------------------------------------------------------------
   initial begin
      int                             n_items;
      logic [mpr_pkg::CSR_DATA_W-1:0] hw_data;
      logic [mpr_pkg::CSR_DATA_W-1:0] deg_data;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Reset settings (one tap pair, first power only) from a fresh fill count.
      offer_sample(16'sh7FFF, 1'b0);
      offer_sample(16'sh8000, 1'b0);
      offer_sample(16'sh0001, 1'b0);
      drain_words();

      // Two taps, four powers. Upper data bits are outside the registers.
      // Writes to the unused indexes must change nothing.
      write_register(mpr_pkg::REG_HALF_WINDOW, 8'hF1);
      write_register(mpr_pkg::REG_DEGREE, 8'hFC);
      write_register(2'd2, 8'hFF);
      write_register(2'd3, 8'h00);

      // Minus one squared saturates to the largest positive value.
      offer_sample(16'sh8000, 1'b1);
      offer_sample(16'sh8000, 1'b0);
      offer_sample(16'sh7FFF, 1'b0);
      offer_sample(16'shFFFF, 1'b0);
      offer_sample(16'sh0001, 1'b0);
      offer_sample(16'sh0000, 1'b0);
      offer_sample(16'sh4000, 1'b0);
      offer_sample(16'shC000, 1'b0);
      // A mark in mid-stream restarts the fill count, so this sample gives no row.
      offer_sample(16'sh5A5A, 1'b1);
      offer_sample(16'shA5A5, 1'b0);
      offer_sample(16'shFFFE, 1'b0);
      drain_words();

      // Zero in both registers is treated as one.
      write_register(mpr_pkg::REG_HALF_WINDOW, 8'hF0);
      write_register(mpr_pkg::REG_DEGREE, 8'h08);
      offer_sample(16'sh1234, 1'b0);
      offer_sample(16'shEDCB, 1'b0);
      offer_sample(16'sh8000, 1'b1);
      drain_words();

      // Random phases, each under its own register setting.
      for (int phase = 0; phase < 8; phase++) begin
         case (phase)
            0: begin hw_data = 8'h08; deg_data = 8'h04; n_items = 50; end
            1: begin hw_data = 8'hFF; deg_data = 8'hFF; n_items = 30; end
            2: begin hw_data = 8'h03; deg_data = 8'h02; n_items = 100; end
            7: begin hw_data = 8'h02; deg_data = 8'h03; n_items = 60; end
            default: begin
               hw_data  = 8'($urandom);
               deg_data = 8'($urandom);
               n_items  = 60;
            end
         endcase
         write_register(mpr_pkg::REG_DEGREE, deg_data);
         write_register(mpr_pkg::REG_HALF_WINDOW, hw_data);
         write_register(mpr_pkg::CSR_INDEX_W'($urandom_range(2, 3)), 8'($urandom));

         // The last phase runs with no idling on either side.
         if (phase == 7) quiet = 1'b1;
         // Here the receiver stalls for a long time while samples keep coming.
         if (phase == 2) hold_request = 1'b1;

         for (int i = 0; i < n_items; i++) begin
            // A phase may open on the previous phase's window or with a mark;
            // later marks are rare so that long windows still fill.
            if (i == 0)
               offer_sample(pick_sample(), 1'($urandom_range(0, 1)));
            else
               offer_sample(pick_sample(), $urandom_range(0, 24) == 0);
         end
         drain_words();
      end

      if (sb.failures == 0)
         $display("memory_polynomial_regressor regression: pass");
      else
         $display("memory_polynomial_regressor regression: fail");
      $finish;
   end

   // Watchdog: far beyond the slowest legal run, including the long stall.
   initial begin
      #20000000;
      $display("memory_polynomial_regressor regression: fail");
      $finish;
   end

endmodule

/* memory_polynomial_regressor.f */
src/mpr_pkg.sv
src/mpr_front.sv
src/mpr_queue.sv
src/mpr_back.sv
src/memory_polynomial_regressor.sv
bench/memory_polynomial_regressor_tb.sv
